[rtl/double_ended_queue_top_defines.svh]
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/dq_pkg.sv]
// Package: deque constants, opcodes, payload and control structs.
package dq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] push_value;
    } dq_in_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [6:0]         entry_count;
        logic               is_empty;
        logic               op_error;
    } dq_out_t;

    typedef struct packed {
        logic exec;      // take the input item and update state
        logic fill_pop;  // load the read word into the result register
    } dq_cmd_t;

    typedef struct packed {
        logic pop_ok;    // current item is a pop on a non-empty deque
    } dq_status_t;

endpackage

[rtl/dq_ctrl.sv]
// Controller: sequences item acceptance, pop read and result handshake.
module dq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  dq_pkg::dq_status_t status,
    output dq_pkg::dq_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_out;

    assign s_ready      = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign cmd.exec     = s_valid && s_ready;
    assign cmd.fill_pop = (state_reg == ST_POP);
    assign m_valid      = out_valid_reg;

    // A successful pop loads its result in the pop state, from the registered store read.
    assign load_out = (cmd.exec && !status.pop_ok) || cmd.fill_pop;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.exec && status.pop_ok) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/dq_datapath.sv]
// Datapath: circular word store, front pointer, count and result register.
module dq_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  dq_pkg::dq_in_t     s_data,
    input  dq_pkg::dq_cmd_t    cmd,
    output dq_pkg::dq_status_t status,
    output dq_pkg::dq_out_t    m_data
);

    logic [dq_pkg::WORD_W-1:0] mem [dq_pkg::DEPTH];

    logic [dq_pkg::ADDR_W-1:0] front_reg, front_next;
    logic [dq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dq_pkg::WORD_W-1:0] rd_data_reg;
    dq_pkg::dq_out_t           out_reg;

    logic                      is_full, is_zero;
    logic                      wr_en, rd_en, err;
    logic [dq_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [dq_pkg::ADDR_W-1:0] back_slot, last_slot, front_dec;

    assign is_full = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign is_zero = (count_reg == '0);

    // Index arithmetic wraps by truncation; the store depth is a power of two.
    assign back_slot = front_reg + count_reg[dq_pkg::ADDR_W-1:0];
    assign last_slot = back_slot - dq_pkg::ADDR_W'(1);
    assign front_dec = front_reg - dq_pkg::ADDR_W'(1);

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        err        = 1'b0;
        wr_addr    = back_slot;
        rd_addr    = front_reg;
        case (s_data.opcode)
            dq_pkg::OP_PUSH_BACK: begin
                if (is_full) begin
                    err = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    err = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (is_zero) begin
                    err = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = last_slot;
                    count_next = count_reg - dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (is_zero) begin
                    err = 1'b1;
                end else begin
                    rd_en      = 1'b1;
                    front_next = front_reg + dq_pkg::ADDR_W'(1);
                    count_next = count_reg - dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::OP_CLEAR: begin
                front_next = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign status.pop_ok = rd_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= s_data.push_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_reg.popped_value <= '0;
            out_reg.entry_count  <= dq_pkg::COUNT_W'(count_next);
            out_reg.is_empty     <= (count_next == '0);
            out_reg.op_error     <= err;
        end else if (cmd.fill_pop) begin
            out_reg.popped_value <= rd_data_reg;
        end
    end

    assign m_data = out_reg;

endmodule

[rtl/double_ended_queue_top.sv]
// Top level: deque of signed words, controller plus datapath.
//
//   channel | direction | payload   | handshake
//   s_      | in        | dq_in_t   | s_valid / s_ready
//   m_      | out       | dq_out_t  | m_valid / m_ready
//
// Push, clear, unused-opcode and failed ops: result registered in the cycle after acceptance.
// Successful pops: the word goes through the registered store read and the pop state first.
// One item is in flight at a time; s_ready drops during the pop read cycle.
// A waiting result does not block acceptance when m_ready is high that cycle.
// Reset (synchronous, aresetn low) empties the deque; no store clearing pass.
module double_ended_queue_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dq_pkg::dq_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_out_t m_data
);

    dq_pkg::dq_cmd_t    cmd;
    dq_pkg::dq_status_t status;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

[rtl/dq_checker.sv]
// Checker: port-level assertions on the deque, bound to the top level.
`include "double_ended_queue_top_defines.svh"

module dq_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input dq_pkg::dq_in_t  s_data,
    input logic            m_valid,
    input logic            m_ready,
    input dq_pkg::dq_out_t m_data
);

    `DQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `DQ_ASSERT_SAME(a_empty_flag, aclk, aresetn, m_valid, m_data.is_empty == (m_data.entry_count == 7'd0))
    `DQ_ASSERT_SAME(a_error_zero, aclk, aresetn, m_valid && m_data.op_error, m_data.popped_value == 32'sd0)
    `DQ_ASSERT_NEXT(a_clear_result, aclk, aresetn, s_valid && s_ready && s_data.opcode == dq_pkg::OP_CLEAR, m_valid && m_data.entry_count == 7'd0 && !m_data.op_error)

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[test/tb_top.sv]
// Testbench for the deque block: random op streams checked against a software deque.
module tb_top;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_AFTER   = 1050;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 10;
    localparam int CYCLE_LIMIT  = 100000;

    class deque_scoreboard;
        logic signed [31:0] words [dq_pkg::DEPTH];
        int                 head;
        int                 fill;
        dq_pkg::dq_out_t    pending [$];
        int                 mismatches;

        function new();
            head = 0;
            fill = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted op to the shadow deque and queue its result.
        function void note_input(dq_pkg::dq_in_t item);
            dq_pkg::dq_out_t r;
            int              slot;
            r = '0;
            case (item.opcode)
                dq_pkg::OP_PUSH_BACK: begin
                    if (fill >= dq_pkg::DEPTH) begin
                        r.op_error = 1'b1;
                    end else begin
                        slot = (head + fill) % dq_pkg::DEPTH;
                        words[slot] = item.push_value;
                        fill++;
                    end
                end
                dq_pkg::OP_PUSH_FRONT: begin
                    if (fill >= dq_pkg::DEPTH) begin
                        r.op_error = 1'b1;
                    end else begin
                        head = (head + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
                        words[head] = item.push_value;
                        fill++;
                    end
                end
                dq_pkg::OP_POP_BACK: begin
                    if (fill == 0) begin
                        r.op_error = 1'b1;
                    end else begin
                        slot = (head + fill - 1) % dq_pkg::DEPTH;
                        r.popped_value = words[slot];
                        fill--;
                    end
                end
                dq_pkg::OP_POP_FRONT: begin
                    if (fill == 0) begin
                        r.op_error = 1'b1;
                    end else begin
                        r.popped_value = words[head];
                        head = (head + 1) % dq_pkg::DEPTH;
                        fill--;
                    end
                end
                dq_pkg::OP_CLEAR: begin
                    fill = 0;
                    head = 0;
                end
                default: begin
                end
            endcase
            r.entry_count = fill[6:0];
            r.is_empty    = (fill == 0);
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h, expected %h", what, got, want);
            mismatches++;
        endtask

        task check_result(dq_pkg::dq_out_t got);
            dq_pkg::dq_out_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing outstanding", got.popped_value, '0);
            end else begin
                want = pending.pop_front();
                if (got.popped_value !== want.popped_value)
                    report_mismatch("popped_value", got.popped_value, want.popped_value);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(got.entry_count),
                                    32'(want.entry_count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                if (got.op_error !== want.op_error)
                    report_mismatch("op_error", 32'(got.op_error), 32'(want.op_error));
            end
        endtask
    endclass

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    dq_pkg::dq_in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    dq_pkg::dq_out_t m_data;

    deque_scoreboard sb;
    int  items_sent = 0;
    bit  calm = 0;
    bit  gaps_on = 1;
    bit  hold_req = 0;

    double_ended_queue_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Result side: random stall bursts, quiet stretches, and one long hold-off.
    initial begin : sink
        int stall_left;
        bit quiet;
        stall_left = 0;
        quiet = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                m_ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                quiet = !quiet;
            @(posedge aclk);
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sh00000000;
            3:       return 32'shFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item, hold it until taken, then maybe leave a short gap.
    task send(logic [2:0] op, logic signed [31:0] value);
        dq_pkg::dq_in_t item;
        item.opcode     = op;
        item.push_value = value;
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (gaps_on && !calm && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending.size() != 0);
        @(posedge aclk);
    endtask

    // Clear, push past full, then pop past empty, mixing both ends.
    task fill_and_drain();
        int extra;
        extra = $urandom_range(1, 3);
        send(dq_pkg::OP_CLEAR, rand_word());
        repeat (dq_pkg::DEPTH + extra)
            send($urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                 rand_word());
        repeat (dq_pkg::DEPTH + extra)
            send($urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK,
                 rand_word());
    endtask

    initial begin : stimulus
        int  run_len;
        int  push_pct;
        int  roll;
        bit  hold_done;
        bit  pause_done;
        sb = new();
        hold_done  = 0;
        pause_done = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(dq_pkg::OP_POP_BACK, 32'sh7FFFFFFF);
        send(dq_pkg::OP_POP_FRONT, 32'sh80000000);
        send(dq_pkg::OP_PUSH_BACK, 32'sh7FFFFFFF);
        send(dq_pkg::OP_PUSH_FRONT, 32'sh80000000);
        send(dq_pkg::OP_PUSH_BACK, 32'sh00000000);
        send(dq_pkg::OP_PUSH_FRONT, 32'shFFFFFFFF);
        send(OP_UNUSED_LO, 32'shAAAAAAAA);
        send(OP_UNUSED_LO + 3'd1, 32'sh55555555);
        send(OP_UNUSED_HI, 32'shFFFFFFFF);
        send(dq_pkg::OP_POP_BACK, 32'sh0);
        send(dq_pkg::OP_POP_FRONT, 32'sh0);
        send(dq_pkg::OP_POP_BACK, 32'sh0);
        send(dq_pkg::OP_POP_FRONT, 32'sh0);
        send(dq_pkg::OP_POP_FRONT, 32'sh0);
        send(dq_pkg::OP_PUSH_FRONT, 32'sh12345678);
        send(dq_pkg::OP_PUSH_BACK, rand_word());
        send(dq_pkg::OP_CLEAR, 32'shFFFFFFFF);
        send(dq_pkg::OP_POP_BACK, 32'sh0);
        send(dq_pkg::OP_CLEAR, 32'sh0);
        send(dq_pkg::OP_PUSH_BACK, rand_word());
        send(dq_pkg::OP_POP_BACK, 32'sh0);

        fill_and_drain();
        while (items_sent < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 9) == 0) begin
                fill_and_drain();
            end else begin
                run_len  = $urandom_range(10, 60);
                push_pct = $urandom_range(30, 75);
                repeat (run_len) begin
                    roll = $urandom_range(0, 99);
                    if (roll < push_pct)
                        send($urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT
                                                  : dq_pkg::OP_PUSH_BACK,
                             rand_word());
                    else if (roll < 95)
                        send($urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT
                                                  : dq_pkg::OP_POP_BACK,
                             rand_word());
                    else if (roll < 97)
                        send(dq_pkg::OP_CLEAR, rand_word());
                    else
                        send(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), rand_word());
                end
            end
            if (!hold_done && items_sent > 300) begin
                hold_req  = 1;
                hold_done = 1;
            end
            if (!pause_done && items_sent > 600) begin
                drain_results();
                pause_done = 1;
            end
            if (items_sent > CALM_AFTER)
                calm = 1;
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (sb.pending.size() != 0)
            sb.report_mismatch("results never arrived", sb.pending.size(), '0);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
